@@ rtl/swtn_pkg.sv @@
// Shared constants, codes and state type of the sparse weight table.
package swtn_pkg;

  localparam int unsigned TABLE_DEPTH_DEF   = 64;
  localparam int unsigned WEIGHT_FRAC_DEF   = 16;
  localparam int unsigned NORM_GUARD_BITS   = 24;
  localparam int unsigned ID_W              = 24;
  localparam int unsigned WT_W              = 32;
  localparam int unsigned FUNC_W            = 3;
  localparam int unsigned STAT_W            = 3;
  localparam int unsigned ENTRY_COUNT_W     = 7;
  localparam int unsigned IN_TDATA_W        = 56;
  localparam int unsigned OUT_TDATA_W       = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD     = 3'd0,
    FUNC_ADD_NEW = 3'd1,
    FUNC_NORM_L1 = 3'd2,
    FUNC_NORM_L2 = 3'd3,
    FUNC_READ    = 3'd4,
    FUNC_CLEAR   = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ACC    = 3'd0,
    ST_INS    = 3'd1,
    ST_KEPT   = 3'd2,
    ST_DROP   = 3'd3,
    ST_LISTED = 3'd4,
    ST_EMPTY  = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SUM_RD,
    S_SUM_MAG,
    S_SUM_ACC,
    S_ROOT,
    S_NORM_CHK,
    S_DIV_RD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_LST_RD,
    S_LST_OUT,
    S_EMIT
  } state_t;

endpackage

@@ rtl/swtn_root.sv @@
// Bit-serial integer square root, one root bit per cycle.
module swtn_root #(
  parameter int unsigned ROOT_W = 59
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [ROOT_W:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_diff;
  logic              fits;

  assign rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign rem_diff = rem_sh - trial;
  assign fits     = rem_sh >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = fits ? rem_diff[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_nxt = {root_r[ROOT_W-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/swtn_div.sv @@
// Restoring fraction divider: round_half_up(num * 2^F / den) for num <= den.
module swtn_div #(
  parameter int unsigned NORM_W = 59,
  parameter int unsigned FRAC_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NORM_W-1:0] num,
  input  logic [NORM_W-1:0] den,
  output logic              done,
  output logic [FRAC_W:0]   quot
);

  localparam int unsigned STEPS = FRAC_W + 2;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              first_r, first_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NORM_W-1:0] rem_r, rem_nxt;
  logic [NORM_W-1:0] den_r, den_nxt;
  logic [FRAC_W+1:0] q_r, q_nxt;
  logic [NORM_W:0]   rem_sh;
  logic              ge;
  logic [FRAC_W+2:0] q_round;

  assign rem_sh  = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign q_round = {1'b0, q_r} + 1'b1;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    if (start) begin
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = num;
      den_nxt   = den;
      q_nxt     = '0;
    end else if (busy_r) begin
      first_nxt = 1'b0;
      rem_nxt   = ge ? NORM_W'(rem_sh - {1'b0, den_r}) : rem_sh[NORM_W-1:0];
      q_nxt     = {q_r[FRAC_W:0], ge};
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    first_r <= first_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    q_r     <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_round[FRAC_W+1:1];

endmodule

@@ rtl/sparse_weight_table_normalize.sv @@
// Sparse weight table with add, insert, L1/L2 normalize, read out and clear.
// The table holds up to TABLE_DEPTH (id, weight) pairs sorted by id in one
// single-port-read memory with a registered read; one operation runs at a time
// and in_tready is high only between operations. An add searches linearly,
// reading and checking each entry passed (S_SRCH_RD, S_SRCH_CHK), then an
// insert shifts the tail, reading and writing each moved entry (S_SHIFT_RD,
// S_SHIFT_WR). Normalize sums the table per entry in S_SUM_RD, S_SUM_MAG and
// S_SUM_ACC, takes the square root for L2 (one root bit per cycle), divides
// each weight (one quotient bit per cycle) and then lists the table, holding
// each entry while the output is stalled. Read out lists only; clear empties
// the table. Results pass through one output register.
module sparse_weight_table_normalize #(
  parameter int unsigned TABLE_DEPTH      = swtn_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = swtn_pkg::WEIGHT_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [swtn_pkg::IN_TDATA_W-1:0]    in_tdata,   // word_id[23:0], value[55:24]
  input  logic [swtn_pkg::FUNC_W-1:0]        in_tuser,   // func[2:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [swtn_pkg::OUT_TDATA_W-1:0]   out_tdata,  // word_id_res[23:0], weight[55:24],
                                                         // entry_count[62:56], zero[63]
  output logic [swtn_pkg::STAT_W-1:0]        out_tuser,  // status[2:0]
  output logic                               out_tlast
);

  localparam int unsigned ID_W   = swtn_pkg::ID_W;
  localparam int unsigned WT_W   = swtn_pkg::WT_W;
  localparam int unsigned G      = swtn_pkg::NORM_GUARD_BITS;
  localparam int unsigned EC_W   = swtn_pkg::ENTRY_COUNT_W;
  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W  = ID_W + WT_W;
  localparam int unsigned SUM_W  = 2 * WT_W - 2 + CNT_W;
  localparam int unsigned ROOT_W = (SUM_W + 2 * G) / 2 + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned NORM_W = ROOT_W;
  localparam int unsigned F      = WEIGHT_FRAC_BITS;

  swtn_pkg::state_t state_r, state_nxt;

  logic [ENT_W-1:0] mem [TABLE_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [ENT_W-1:0] mem_wr_data;

  swtn_pkg::func_t   func_r, func_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic [WT_W-1:0]   val_r, val_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [2*WT_W-1:0] prod_r, prod_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [WT_W-1:0]   res_w_r, res_w_nxt;
  swtn_pkg::status_t res_st_r, res_st_nxt;

  logic                    out_valid_r;
  logic [ID_W-1:0]         out_id_r, out_id_nxt;
  logic [WT_W-1:0]         out_w_r, out_w_nxt;
  swtn_pkg::status_t       out_st_r, out_st_nxt;
  logic [EC_W-1:0]         out_cnt_r, out_cnt_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_load;
  logic                    out_free;

  logic [ID_W-1:0]     rd_id;
  logic [WT_W-1:0]     rd_w;
  logic [WT_W-1:0]     rd_mag;
  logic [WT_W:0]       sat_wide;
  logic [WT_W-1:0]     sat_sum;
  logic                is_l2;
  logic                full;
  logic [CNT_W-1:0]    j_dec;
  logic [CNT_W-1:0]    ptr_inc;
  logic [CNT_W+EC_W-1:0] fill_ext;
  logic [RAD_W-1:0]    radicand;
  logic                root_start;
  logic                root_done;
  logic [ROOT_W-1:0]   root_q;
  logic [NORM_W-1:0]   norm;
  logic                div_start;
  logic                div_done;
  logic [NORM_W-1:0]   div_num;
  logic [F:0]          div_q;
  logic [WT_W-1:0]     q_ext;
  logic [WT_W-1:0]     w_new;
  logic                in_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign rd_id    = rd_data_r[ID_W-1:0];
  assign rd_w     = rd_data_r[ENT_W-1:ID_W];
  assign rd_mag   = rd_w[WT_W-1] ? (~rd_w + 1'b1) : rd_w;
  assign sat_wide = {rd_w[WT_W-1], rd_w} + {val_r[WT_W-1], val_r};
  assign sat_sum  = (sat_wide[WT_W] != sat_wide[WT_W-1]) ?
                    (sat_wide[WT_W] ? {1'b1, {(WT_W-1){1'b0}}} : {1'b0, {(WT_W-1){1'b1}}}) :
                    sat_wide[WT_W-1:0];
  assign is_l2    = func_r == swtn_pkg::FUNC_NORM_L2;
  assign full     = fill_r == CNT_W'(TABLE_DEPTH);
  assign j_dec    = j_r - 1'b1;
  assign ptr_inc  = ptr_r + 1'b1;
  assign fill_ext = {{EC_W{1'b0}}, fill_r};
  assign radicand = {{(RAD_W-SUM_W-2*G){1'b0}}, acc_r, {(2*G){1'b0}}};
  assign norm     = is_l2 ? root_q : acc_r[NORM_W-1:0];
  assign div_num  = is_l2 ? {{(NORM_W-WT_W-G){1'b0}}, rd_mag, {G{1'b0}}}
                          : {{(NORM_W-WT_W){1'b0}}, rd_mag};
  assign q_ext    = {{(WT_W-F-1){1'b0}}, div_q};
  assign w_new    = rd_w[WT_W-1] ? (~q_ext + 1'b1) : q_ext;

  swtn_root #(.ROOT_W(ROOT_W)) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root_q)
  );

  swtn_div #(.NORM_W(NORM_W), .FRAC_W(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (norm),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_r <= mem[mem_rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swtn_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = swtn_pkg::S_DECODE;
      end
      swtn_pkg::S_DECODE: begin
        case (func_r)
          swtn_pkg::FUNC_ADD, swtn_pkg::FUNC_ADD_NEW: state_nxt = swtn_pkg::S_SRCH_RD;
          swtn_pkg::FUNC_NORM_L1, swtn_pkg::FUNC_NORM_L2: begin
            state_nxt = (fill_r == '0) ? swtn_pkg::S_EMIT : swtn_pkg::S_SUM_RD;
          end
          swtn_pkg::FUNC_READ: begin
            state_nxt = (fill_r == '0) ? swtn_pkg::S_EMIT : swtn_pkg::S_LST_RD;
          end
          swtn_pkg::FUNC_CLEAR: state_nxt = swtn_pkg::S_EMIT;
          default: state_nxt = swtn_pkg::S_IDLE;
        endcase
      end
      swtn_pkg::S_SRCH_RD: begin
        if (ptr_r != fill_r) state_nxt = swtn_pkg::S_SRCH_CHK;
        else if (full) state_nxt = swtn_pkg::S_EMIT;
        else state_nxt = swtn_pkg::S_SHIFT_RD;
      end
      swtn_pkg::S_SRCH_CHK: begin
        if (rd_id < key_r) state_nxt = swtn_pkg::S_SRCH_RD;
        else if (rd_id == key_r || full) state_nxt = swtn_pkg::S_EMIT;
        else state_nxt = swtn_pkg::S_SHIFT_RD;
      end
      swtn_pkg::S_SHIFT_RD: begin
        state_nxt = (j_r == ptr_r) ? swtn_pkg::S_EMIT : swtn_pkg::S_SHIFT_WR;
      end
      swtn_pkg::S_SHIFT_WR: state_nxt = swtn_pkg::S_SHIFT_RD;
      swtn_pkg::S_SUM_RD: begin
        if (ptr_r != fill_r) state_nxt = swtn_pkg::S_SUM_MAG;
        else state_nxt = is_l2 ? swtn_pkg::S_ROOT : swtn_pkg::S_NORM_CHK;
      end
      swtn_pkg::S_SUM_MAG: state_nxt = swtn_pkg::S_SUM_ACC;
      swtn_pkg::S_SUM_ACC: state_nxt = swtn_pkg::S_SUM_RD;
      swtn_pkg::S_ROOT: begin
        if (root_done) state_nxt = swtn_pkg::S_NORM_CHK;
      end
      swtn_pkg::S_NORM_CHK: begin
        state_nxt = (norm == '0) ? swtn_pkg::S_LST_RD : swtn_pkg::S_DIV_RD;
      end
      swtn_pkg::S_DIV_RD: begin
        state_nxt = (ptr_r == fill_r) ? swtn_pkg::S_LST_RD : swtn_pkg::S_DIV_GO;
      end
      swtn_pkg::S_DIV_GO: state_nxt = swtn_pkg::S_DIV_WAIT;
      swtn_pkg::S_DIV_WAIT: begin
        if (div_done) state_nxt = swtn_pkg::S_DIV_RD;
      end
      swtn_pkg::S_LST_RD: state_nxt = swtn_pkg::S_LST_OUT;
      swtn_pkg::S_LST_OUT: begin
        if (out_free) begin
          state_nxt = (ptr_inc == fill_r) ? swtn_pkg::S_IDLE : swtn_pkg::S_LST_RD;
        end
      end
      swtn_pkg::S_EMIT: begin
        if (out_free) state_nxt = swtn_pkg::S_IDLE;
      end
      default: state_nxt = swtn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = state_r == swtn_pkg::S_IDLE;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = ptr_r[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_wr_addr  = ptr_r[IDX_W-1:0];
    mem_wr_data  = {rd_w, rd_id};
    root_start   = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    func_nxt     = func_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    fill_nxt     = fill_r;
    ptr_nxt      = ptr_r;
    j_nxt        = j_r;
    acc_nxt      = acc_r;
    prod_nxt     = prod_r;
    res_id_nxt   = res_id_r;
    res_w_nxt    = res_w_r;
    res_st_nxt   = res_st_r;
    out_id_nxt   = res_id_r;
    out_w_nxt    = res_w_r;
    out_st_nxt   = res_st_r;
    out_cnt_nxt  = fill_ext[EC_W-1:0];
    out_last_nxt = 1'b1;
    case (state_r)
      swtn_pkg::S_IDLE: begin
        if (in_xfer) begin
          func_nxt = swtn_pkg::func_t'(in_tuser);
          key_nxt  = in_tdata[ID_W-1:0];
          val_nxt  = in_tdata[ENT_W-1:ID_W];
        end
      end
      swtn_pkg::S_DECODE: begin
        ptr_nxt    = '0;
        acc_nxt    = '0;
        res_id_nxt = '0;
        res_w_nxt  = '0;
        res_st_nxt = swtn_pkg::ST_EMPTY;
        if (func_r == swtn_pkg::FUNC_CLEAR) fill_nxt = '0;
      end
      swtn_pkg::S_SRCH_RD: begin
        mem_rd_en  = ptr_r != fill_r;
        res_id_nxt = key_r;
        res_w_nxt  = '0;
        res_st_nxt = swtn_pkg::ST_DROP;
        j_nxt      = fill_r;
      end
      swtn_pkg::S_SRCH_CHK: begin
        res_id_nxt = key_r;
        j_nxt      = fill_r;
        if (rd_id < key_r) begin
          ptr_nxt = ptr_inc;
        end else if (rd_id == key_r) begin
          if (func_r == swtn_pkg::FUNC_ADD) begin
            mem_we      = 1'b1;
            mem_wr_data = {sat_sum, rd_id};
            res_w_nxt   = sat_sum;
            res_st_nxt  = swtn_pkg::ST_ACC;
          end else begin
            res_w_nxt  = rd_w;
            res_st_nxt = swtn_pkg::ST_KEPT;
          end
        end else begin
          res_w_nxt  = '0;
          res_st_nxt = swtn_pkg::ST_DROP;
        end
      end
      swtn_pkg::S_SHIFT_RD: begin
        if (j_r == ptr_r) begin
          mem_we      = 1'b1;
          mem_wr_data = {val_r, key_r};
          fill_nxt    = fill_r + 1'b1;
          res_id_nxt  = key_r;
          res_w_nxt   = val_r;
          res_st_nxt  = swtn_pkg::ST_INS;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = j_dec[IDX_W-1:0];
        end
      end
      swtn_pkg::S_SHIFT_WR: begin
        mem_we      = 1'b1;
        mem_wr_addr = j_r[IDX_W-1:0];
        j_nxt       = j_dec;
      end
      swtn_pkg::S_SUM_RD: begin
        mem_rd_en  = ptr_r != fill_r;
        root_start = (ptr_r == fill_r) && is_l2;
      end
      swtn_pkg::S_SUM_MAG: begin
        prod_nxt = is_l2 ? rd_mag * rd_mag : {{WT_W{1'b0}}, rd_mag};
      end
      swtn_pkg::S_SUM_ACC: begin
        acc_nxt = acc_r + {{(SUM_W-2*WT_W){1'b0}}, prod_r};
        ptr_nxt = ptr_inc;
      end
      swtn_pkg::S_NORM_CHK: begin
        ptr_nxt = '0;
      end
      swtn_pkg::S_DIV_RD: begin
        mem_rd_en = ptr_r != fill_r;
        if (ptr_r == fill_r) ptr_nxt = '0;
      end
      swtn_pkg::S_DIV_GO: begin
        div_start = 1'b1;
      end
      swtn_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          mem_we      = 1'b1;
          mem_wr_data = {w_new, rd_id};
          ptr_nxt     = ptr_inc;
        end
      end
      swtn_pkg::S_LST_RD: begin
        mem_rd_en = 1'b1;
      end
      swtn_pkg::S_LST_OUT: begin
        out_id_nxt   = rd_id;
        out_w_nxt    = rd_w;
        out_st_nxt   = swtn_pkg::ST_LISTED;
        out_last_nxt = ptr_inc == fill_r;
        if (out_free) begin
          out_load = 1'b1;
          ptr_nxt  = ptr_inc;
        end
      end
      swtn_pkg::S_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swtn_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    ptr_r    <= ptr_nxt;
    j_r      <= j_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    res_id_r <= res_id_nxt;
    res_w_r  <= res_w_nxt;
    res_st_r <= res_st_nxt;
    if (out_load) begin
      out_id_r   <= out_id_nxt;
      out_w_r    <= out_w_nxt;
      out_st_r   <= out_st_nxt;
      out_cnt_r  <= out_cnt_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_w_r, out_id_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> (fill_r == '0 || fill_r == $past(fill_r) + 1'b1))
    else $error("fill count changed by other than insert or clear");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, mem_wr_addr} <= {1'b0, fill_r}))
    else $error("table write beyond the filled region");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten while held");

endmodule
